### src/ccam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccam_pkg: shared types and constants of the clock calendar alarm monitor
// Command codes, register indexes, reset values and the temperature scaling.
// ----------------------------------------------------------------------------
package ccam_pkg;

	// command carried in s_tuser
	typedef enum logic [1:0] {
		FUNC_TICK      = 2'd0,
		FUNC_STOP      = 2'd1,
		FUNC_LOAD_TIME = 2'd2,
		FUNC_LOAD_DATE = 2'd3
	} func_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALARM_EN  = 3'd0,
		CFG_AL_HR_T   = 3'd1,
		CFG_AL_HR_O   = 3'd2,
		CFG_AL_MN_T   = 3'd3,
		CFG_AL_MN_O   = 3'd4,
		CFG_TEMP_LOW  = 3'd5,
		CFG_TEMP_HIGH = 3'd6
	} cfg_idx_t;

	// band classification
	localparam logic [1:0] TS_BELOW  = 2'd0;
	localparam logic [1:0] TS_WITHIN = 2'd1;
	localparam logic [1:0] TS_ABOVE  = 2'd2;

	// degrees = floor(adc * 488 / 1000) = floor(adc * 61 / 125), done as
	// (adc * 61 * ceil(2^23 / 125)) >> 23, exact over the whole 10-bit range
	localparam logic [21:0] TEMP_RECIP = 22'd4093649;
	localparam int          TEMP_SHIFT = 23;

	localparam logic [5:0] RING_TICKS = 6'd60;
	localparam logic [13:0] YEAR_WRAP = 14'd10000;

	// reset values
	localparam logic [1:0]  RST_HR_TENS = 2'd1;
	localparam logic [3:0]  RST_HR_ONES = 4'd2;
	localparam logic [2:0]  RST_MN_TENS = 3'd4;
	localparam logic [3:0]  RST_MN_ONES = 4'd5;
	localparam logic [13:0] RST_YEAR    = 14'd1400;
	localparam logic [3:0]  RST_MONTH   = 4'd3;
	localparam logic [4:0]  RST_DAY     = 5'd20;
	localparam logic [1:0]  RST_AL_HR_T = 2'd1;
	localparam logic [3:0]  RST_AL_HR_O = 4'd3;
	localparam logic [2:0]  RST_AL_MN_T = 3'd3;
	localparam logic [3:0]  RST_AL_MN_O = 4'd0;
	localparam logic [6:0]  RST_T_LOW   = 7'd18;
	localparam logic [6:0]  RST_T_HIGH  = 7'd25;

endpackage

### src/clock_calendar_alarm_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_calendar_alarm_monitor: BCD clock, calendar, alarm and thermometer
// One result item per command item: tick, stop alarm, load time, load date.
// ----------------------------------------------------------------------------
// Every accepted item yields one result item carrying the clock, the date,
// the last temperature, its class against the band and the buzzer flag. The
// block takes one item per clock cycle while its results drain; each item
// passes the input register and then the result register, and the whole
// state update (clock rollover chain, reciprocal multiply for the degrees,
// alarm compare and ring counter) is one combinational pass between those
// two registers. A stalled result register holds the input register, which
// in turn drops s_tready. Configuration is to be written through cfg_wen/
// cfg_addr/cfg_wdata only while the block is idle, which the block does not
// enforce; writes to an index past the last register are ignored.
// ----------------------------------------------------------------------------
module clock_calendar_alarm_monitor (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_addr,
	input  logic [6:0]  cfg_wdata,
	// command items
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata, from bit 0: adc_sample[9:0], set_hour_tens[11:10],
	// set_hour_ones[15:12], set_min_tens[18:16], set_min_ones[22:19],
	// set_year[36:23], set_month[40:37], set_day[45:41], zero [47:46]
	input  logic [47:0] s_tdata,
	// s_tuser: func[1:0]
	input  logic [1:0]  s_tuser,
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata, from bit 0: hour_tens[1:0], hour_ones[5:2], min_tens[8:6],
	// min_ones[12:9], sec_tens[15:13], sec_ones[19:16], year[33:20],
	// month[37:34], day[42:38], temperature[51:43], temp_status[53:52],
	// buzzer[54], zero [55]
	output logic [55:0] m_tdata
);

	// ---------------------------------------------------------------- config
	logic       al_en_q;
	logic [1:0] al_hr_t_q;
	logic [3:0] al_hr_o_q;
	logic [2:0] al_mn_t_q;
	logic [3:0] al_mn_o_q;
	logic [6:0] t_low_q;
	logic [6:0] t_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			al_en_q   <= 1'b0;
			al_hr_t_q <= ccam_pkg::RST_AL_HR_T;
			al_hr_o_q <= ccam_pkg::RST_AL_HR_O;
			al_mn_t_q <= ccam_pkg::RST_AL_MN_T;
			al_mn_o_q <= ccam_pkg::RST_AL_MN_O;
			t_low_q   <= ccam_pkg::RST_T_LOW;
			t_high_q  <= ccam_pkg::RST_T_HIGH;
		end else if (cfg_wen) begin
			unique case (ccam_pkg::cfg_idx_t'(cfg_addr))
				ccam_pkg::CFG_ALARM_EN:  al_en_q   <= cfg_wdata[0];
				ccam_pkg::CFG_AL_HR_T:   al_hr_t_q <= cfg_wdata[1:0];
				ccam_pkg::CFG_AL_HR_O:   al_hr_o_q <= cfg_wdata[3:0];
				ccam_pkg::CFG_AL_MN_T:   al_mn_t_q <= cfg_wdata[2:0];
				ccam_pkg::CFG_AL_MN_O:   al_mn_o_q <= cfg_wdata[3:0];
				ccam_pkg::CFG_TEMP_LOW:  t_low_q   <= cfg_wdata;
				ccam_pkg::CFG_TEMP_HIGH: t_high_q  <= cfg_wdata;
				default: ;  // unused index: drop the write
			endcase
		end
	end

	// ------------------------------------------------------- input register
	logic                valid_s1;
	ccam_pkg::func_t     func_s1;
	logic [47:0]         data_s1;
	logic                out_valid_q;
	logic [55:0]         result_q;
	logic                adv_s1;

	// the item in s1 moves on whenever the result register is free or drains
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= ccam_pkg::func_t'(s_tuser);
			data_s1 <= s_tdata;
		end
	end

	// unpack the held item
	logic [9:0]  adc_s1;
	logic [1:0]  set_ht_s1;
	logic [3:0]  set_ho_s1;
	logic [2:0]  set_mt_s1;
	logic [3:0]  set_mo_s1;
	logic [13:0] set_yr_s1;
	logic [3:0]  set_mon_s1;
	logic [4:0]  set_day_s1;

	assign adc_s1     = data_s1[9:0];
	assign set_ht_s1  = data_s1[11:10];
	assign set_ho_s1  = data_s1[15:12];
	assign set_mt_s1  = data_s1[18:16];
	assign set_mo_s1  = data_s1[22:19];
	assign set_yr_s1  = data_s1[36:23];
	assign set_mon_s1 = data_s1[40:37];
	assign set_day_s1 = data_s1[45:41];

	// ------------------------------------------------------------ state
	logic [1:0]  hr_tens_q;
	logic [3:0]  hr_ones_q;
	logic [2:0]  mn_tens_q;
	logic [3:0]  mn_ones_q;
	logic [2:0]  sc_tens_q;
	logic [3:0]  sc_ones_q;
	logic [13:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic        ringing_q;
	logic [5:0]  ring_cnt_q;
	logic        armed_q;
	logic [8:0]  temp_q;

	// ---------------------------------------------------- clock rollover
	// Widened by one bit so that an out-of-range digit plus one still
	// compares as "reached or passed".
	logic [4:0]  so_w, mo_w, ho_w;
	logic [3:0]  st_w, mt_w;
	logic [2:0]  ht_w;
	logic [5:0]  dy_w;
	logic [4:0]  mon_w;
	logic [14:0] yr_w;
	logic [6:0]  hr_val;

	always_comb begin
		so_w  = {1'b0, sc_ones_q} + 5'd1;
		st_w  = {1'b0, sc_tens_q};
		mo_w  = {1'b0, mn_ones_q};
		mt_w  = {1'b0, mn_tens_q};
		ho_w  = {1'b0, hr_ones_q};
		ht_w  = {1'b0, hr_tens_q};
		dy_w  = {1'b0, day_q};
		mon_w = {1'b0, month_q};
		yr_w  = {1'b0, year_q};
		if (so_w >= 5'd10) begin
			so_w = '0;
			st_w = st_w + 4'd1;
		end
		if (st_w >= 4'd6) begin
			st_w = '0;
			mo_w = mo_w + 5'd1;
		end
		if (mo_w >= 5'd10) begin
			mo_w = '0;
			mt_w = mt_w + 4'd1;
		end
		if (mt_w >= 4'd6) begin
			mt_w = '0;
			ho_w = ho_w + 5'd1;
		end
		if (ho_w >= 5'd10) begin
			ho_w = '0;
			ht_w = ht_w + 3'd1;
		end
		hr_val = {4'd0, ht_w} * 7'd10 + {2'd0, ho_w};
		// hour 24 or more clears both hour digits and rolls the day
		if (hr_val >= 7'd24) begin
			ht_w = '0;
			ho_w = '0;
			dy_w = dy_w + 6'd1;
		end
		if (dy_w >= 6'd30) begin
			dy_w  = '0;
			mon_w = mon_w + 5'd1;
		end
		if (mon_w >= 5'd12) begin
			mon_w = '0;
			yr_w  = yr_w + 15'd1;
		end
		if (yr_w >= {1'b0, ccam_pkg::YEAR_WRAP}) begin
			yr_w = '0;
		end
	end

	// --------------------------------------------------------- temperature
	logic [31:0] temp_prod;
	logic [8:0]  temp_tick;

	assign temp_prod = {22'd0, adc_s1} * {10'd0, ccam_pkg::TEMP_RECIP};
	assign temp_tick = temp_prod[ccam_pkg::TEMP_SHIFT +: 9];

	// ------------------------------------------------------------ next state
	logic [1:0]  n_hr_tens;
	logic [3:0]  n_hr_ones;
	logic [2:0]  n_mn_tens;
	logic [3:0]  n_mn_ones;
	logic [2:0]  n_sc_tens;
	logic [3:0]  n_sc_ones;
	logic [13:0] n_year;
	logic [3:0]  n_month;
	logic [4:0]  n_day;
	logic        n_ringing;
	logic [5:0]  n_ring_cnt;
	logic        n_armed;
	logic [8:0]  n_temp;
	logic        n_beep;
	logic [1:0]  n_status;
	logic [1:0]  tick_status;
	logic        al_match;
	logic [6:0]  ring_inc;

	// classify a value against the band; below is tested first
	function automatic logic [1:0] classify(input logic [8:0] t, input logic [6:0] lo,
		input logic [6:0] hi);
		if (t < {2'd0, lo}) begin
			return ccam_pkg::TS_BELOW;
		end
		if (t > {2'd0, hi}) begin
			return ccam_pkg::TS_ABOVE;
		end
		return ccam_pkg::TS_WITHIN;
	endfunction

	assign tick_status = classify(temp_tick, t_low_q, t_high_q);

	// alarm compares against the advanced time, at hh:mm:00
	assign al_match = al_en_q && (ht_w[1:0] == al_hr_t_q) && (ho_w[3:0] == al_hr_o_q)
		&& (mt_w[2:0] == al_mn_t_q) && (mo_w[3:0] == al_mn_o_q)
		&& (st_w == 4'd0) && (so_w == 5'd0);

	always_comb begin
		n_hr_tens  = hr_tens_q;
		n_hr_ones  = hr_ones_q;
		n_mn_tens  = mn_tens_q;
		n_mn_ones  = mn_ones_q;
		n_sc_tens  = sc_tens_q;
		n_sc_ones  = sc_ones_q;
		n_year     = year_q;
		n_month    = month_q;
		n_day      = day_q;
		n_ringing  = ringing_q;
		n_ring_cnt = ring_cnt_q;
		n_armed    = armed_q;
		n_temp     = temp_q;
		n_beep     = 1'b0;
		ring_inc   = '0;
		unique case (func_s1)
			ccam_pkg::FUNC_TICK: begin
				n_hr_tens = ht_w[1:0];
				n_hr_ones = ho_w[3:0];
				n_mn_tens = mt_w[2:0];
				n_mn_ones = mo_w[3:0];
				n_sc_tens = st_w[2:0];
				n_sc_ones = so_w[3:0];
				n_year    = yr_w[13:0];
				n_month   = mon_w[3:0];
				n_day     = dy_w[4:0];
				n_temp    = temp_tick;
				// band beep fires once on leaving; an in-band tick re-arms
				if (tick_status == ccam_pkg::TS_WITHIN) begin
					n_armed = 1'b1;
				end else if (armed_q) begin
					n_beep  = 1'b1;
					n_armed = 1'b0;
				end
				if (al_match) begin
					n_ring_cnt = '0;
					n_ringing  = 1'b1;
				end
				if (n_ringing) begin
					ring_inc   = {1'b0, n_ring_cnt} + 7'd1;
					n_ring_cnt = ring_inc[5:0];
					if (ring_inc > {1'b0, ccam_pkg::RING_TICKS}) begin
						n_ringing = 1'b0;
					end else begin
						n_beep = 1'b1;
					end
				end
			end
			ccam_pkg::FUNC_STOP: begin
				n_ringing = 1'b0;
			end
			ccam_pkg::FUNC_LOAD_TIME: begin
				n_hr_tens = set_ht_s1;
				n_hr_ones = set_ho_s1;
				n_mn_tens = set_mt_s1;
				n_mn_ones = set_mo_s1;
				n_sc_tens = '0;
				n_sc_ones = '0;
			end
			ccam_pkg::FUNC_LOAD_DATE: begin
				n_year  = set_yr_s1;
				n_month = set_mon_s1;
				n_day   = set_day_s1;
			end
		endcase
		n_status = classify(n_temp, t_low_q, t_high_q);
	end

	// advance the state once per item leaving s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hr_tens_q  <= ccam_pkg::RST_HR_TENS;
			hr_ones_q  <= ccam_pkg::RST_HR_ONES;
			mn_tens_q  <= ccam_pkg::RST_MN_TENS;
			mn_ones_q  <= ccam_pkg::RST_MN_ONES;
			sc_tens_q  <= '0;
			sc_ones_q  <= '0;
			year_q     <= ccam_pkg::RST_YEAR;
			month_q    <= ccam_pkg::RST_MONTH;
			day_q      <= ccam_pkg::RST_DAY;
			ringing_q  <= 1'b0;
			ring_cnt_q <= '0;
			armed_q    <= 1'b0;
			temp_q     <= '0;
		end else if (adv_s1) begin
			hr_tens_q  <= n_hr_tens;
			hr_ones_q  <= n_hr_ones;
			mn_tens_q  <= n_mn_tens;
			mn_ones_q  <= n_mn_ones;
			sc_tens_q  <= n_sc_tens;
			sc_ones_q  <= n_sc_ones;
			year_q     <= n_year;
			month_q    <= n_month;
			day_q      <= n_day;
			ringing_q  <= n_ringing;
			ring_cnt_q <= n_ring_cnt;
			armed_q    <= n_armed;
			temp_q     <= n_temp;
		end
	end

	// ------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q <= {1'b0, n_beep, n_status, n_temp, n_day, n_month, n_year,
				n_sc_ones, n_sc_tens, n_mn_ones, n_mn_tens, n_hr_ones, n_hr_tens};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q;

	// ------------------------------------------------------------ assertions
	// ring counter never passes the ring length while ringing
	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ringing_q |-> (ring_cnt_q <= ccam_pkg::RING_TICKS))
		else $error("ring counter past ring length while ringing");

	// after a tick the hour is always a legal hour of the day
	a_hour_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (func_s1 == ccam_pkg::FUNC_TICK))
		|=> (({5'd0, hr_tens_q} * 7'd10 + {3'd0, hr_ones_q}) < 7'd24))
		else $error("hour out of range after tick");

	// only a tick can sound the buzzer
	a_beep_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (func_s1 != ccam_pkg::FUNC_TICK)) |=> !m_tdata[54])
		else $error("buzzer on a non-tick item");

	// a full s1 behind a stalled result must hold off new items
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input accepted while both stages are stalled");

endmodule

### tb/clock_calendar_alarm_monitor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_calendar_alarm_monitor_tb: self-checking bench for the clock monitor
// Commands go in on the slave stream and results come back on the master
// stream. Each result is checked against a hand-typed result or an in-bench
// model of the clock, the calendar, the band beep and the alarm ring. A short
// directed table comes first. Randomised alarm runs, rollover runs and noise
// follow, under several register settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module clock_calendar_alarm_monitor_tb;

	localparam int PHASE_ITEMS = 200;     // random items per register setting
	localparam int NUM_PHASES  = 5;
	localparam int HOLD_AT     = 100;     // result count that starts the long hold-off
	localparam int HOLD_CYCLES = 200;
	localparam int MAX_REPORTS = 10;
	localparam int LIMIT       = 200000;  // cycles before the run is declared hung

	// one command item, all fields at their port widths
	typedef struct packed {
		ccam_pkg::func_t func;
		logic [9:0]      adc;
		logic [1:0]      set_ht;
		logic [3:0]      set_ho;
		logic [2:0]      set_mt;
		logic [3:0]      set_mo;
		logic [13:0]     set_yr;
		logic [3:0]      set_mon;
		logic [4:0]      set_dy;
	} cmd_t;

	// one result item as unpacked from m_tdata
	typedef struct packed {
		logic [1:0]  ht;
		logic [3:0]  ho;
		logic [2:0]  mt;
		logic [3:0]  mo;
		logic [2:0]  st;
		logic [3:0]  so;
		logic [13:0] yr;
		logic [3:0]  mon;
		logic [4:0]  dy;
		logic [8:0]  deg;
		logic [1:0]  cls;
		logic        bz;
	} result_t;

	// a row of the directed table; chk marks a result typed in by hand
	typedef struct packed {
		cmd_t    cmd;
		logic    chk;
		result_t res;
	} step_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [2:0]  cfg_addr  = '0;
	logic [6:0]  cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [55:0] m_tdata;

	clock_calendar_alarm_monitor uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Clock model: time, date, thermometer and bell, plus its own copy of
	// the registers. Counters are held as int so that an out-of-range digit
	// can step past its limit exactly as the hardware chain sees it.
	// ------------------------------------------------------------------
	int now_ht, now_ho, now_mt, now_mo, now_st, now_so;
	int now_yr, now_mon, now_day;
	int bell_on, bell_cnt, therm_armed, therm_deg;

	logic       al_en;
	logic [1:0] al_ht;
	logic [3:0] al_ho;
	logic [2:0] al_mt;
	logic [3:0] al_mo;
	logic [6:0] band_lo, band_hi;

	result_t expected_q[$];     // results still owed by the block
	int      items_sent   = 0;
	int      results_seen = 0;
	int      mismatches   = 0;
	int      strays       = 0;  // results that arrived with nothing owed
	int      cycle_cnt    = 0;
	bit      src_steady   = 1'b0;
	bit      snk_steady   = 1'b0;
	bit      long_hold_done = 1'b0;

	// below is tested first, so an inverted band reads as below or above, never within
	function automatic logic [1:0] band_of(int deg);
		if (deg < int'(band_lo))
			return ccam_pkg::TS_BELOW;
		else if (deg > int'(band_hi))
			return ccam_pkg::TS_ABOVE;
		return ccam_pkg::TS_WITHIN;
	endfunction

	// apply one command to the model and return the result it owes
	function automatic result_t clock_after(cmd_t c);
		result_t    r;
		logic       beep;
		logic [1:0] cls;
		beep = 1'b0;
		case (c.func)
			ccam_pkg::FUNC_TICK: begin
				// every rollover is "reached or passed", checked on each tick
				now_so++;
				if (now_so >= 10) begin now_so = 0; now_st++; end
				if (now_st >= 6) begin now_st = 0; now_mo++; end
				if (now_mo >= 10) begin now_mo = 0; now_mt++; end
				if (now_mt >= 6) begin now_mt = 0; now_ho++; end
				if (now_ho >= 10) begin now_ho = 0; now_ht++; end
				if (now_ht * 10 + now_ho >= 24) begin
					now_ht = 0;
					now_ho = 0;
					now_day++;
				end
				if (now_day >= 30) begin now_day = 0; now_mon++; end
				if (now_mon >= 12) begin now_mon = 0; now_yr++; end
				if (now_yr >= int'(ccam_pkg::YEAR_WRAP)) now_yr = 0;

				// one-shot beep on leaving the band, re-armed inside it
				therm_deg = (int'(c.adc) * 488) / 1000;
				cls = band_of(therm_deg);
				if (cls == ccam_pkg::TS_WITHIN) begin
					therm_armed = 1;
				end else if (therm_armed != 0) begin
					beep = 1'b1;
					therm_armed = 0;
				end

				if (al_en && now_ht == int'(al_ht) && now_ho == int'(al_ho) &&
						now_mt == int'(al_mt) && now_mo == int'(al_mo) &&
						now_st == 0 && now_so == 0) begin
					bell_cnt = 0;
					bell_on = 1;
				end
				if (bell_on != 0) begin
					bell_cnt++;
					if (bell_cnt > int'(ccam_pkg::RING_TICKS))
						bell_on = 0;
					else
						beep = 1'b1;
				end
			end
			ccam_pkg::FUNC_STOP: begin
				bell_on = 0;
			end
			ccam_pkg::FUNC_LOAD_TIME: begin
				now_ht = c.set_ht;
				now_ho = c.set_ho;
				now_mt = c.set_mt;
				now_mo = c.set_mo;
				now_st = 0;
				now_so = 0;
			end
			default: begin
				now_yr  = c.set_yr;
				now_mon = c.set_mon;
				now_day = c.set_dy;
			end
		endcase

		// trim back to register widths
		now_ht &= 'h3;  now_ho &= 'hF;  now_mt &= 'h7;  now_mo &= 'hF;
		now_st &= 'h7;  now_so &= 'hF;  now_yr &= 'h3FFF;
		now_mon &= 'hF; now_day &= 'h1F; bell_cnt &= 'h3F;

		r.ht  = now_ht[1:0];
		r.ho  = now_ho[3:0];
		r.mt  = now_mt[2:0];
		r.mo  = now_mo[3:0];
		r.st  = now_st[2:0];
		r.so  = now_so[3:0];
		r.yr  = now_yr[13:0];
		r.mon = now_mon[3:0];
		r.dy  = now_day[4:0];
		r.deg = therm_deg[8:0];
		r.cls = band_of(therm_deg);
		r.bz  = beep;
		return r;
	endfunction

	function automatic cmd_t mk_cmd(ccam_pkg::func_t f, int adc, int ht, int ho, int mt,
			int mo, int yr, int mon, int dy);
		cmd_t c;
		c.func    = f;
		c.adc     = adc[9:0];
		c.set_ht  = ht[1:0];
		c.set_ho  = ho[3:0];
		c.set_mt  = mt[2:0];
		c.set_mo  = mo[3:0];
		c.set_yr  = yr[13:0];
		c.set_mon = mon[3:0];
		c.set_dy  = dy[4:0];
		return c;
	endfunction

	function automatic result_t mk_res(int ht, int ho, int mt, int mo, int st, int so,
			int yr, int mon, int dy, int deg, logic [1:0] cls, logic bz);
		result_t r;
		r.ht  = ht[1:0];
		r.ho  = ho[3:0];
		r.mt  = mt[2:0];
		r.mo  = mo[3:0];
		r.st  = st[2:0];
		r.so  = so[3:0];
		r.yr  = yr[13:0];
		r.mon = mon[3:0];
		r.dy  = dy[4:0];
		r.deg = deg[8:0];
		r.cls = cls;
		r.bz  = bz;
		return r;
	endfunction

	function automatic step_row_t step(cmd_t c, logic chk, result_t r);
		step_row_t s;
		s.cmd = c;
		s.chk = chk;
		s.res = r;
		return s;
	endfunction

	// every field drawn over its full width, so each bit sees both values
	function automatic cmd_t rand_cmd(ccam_pkg::func_t f);
		return mk_cmd(f, $urandom_range(0, 1023), $urandom_range(0, 3),
			$urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 15),
			$urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
	endfunction

	// mostly samples near the band edges so the beep gets exercised
	function automatic logic [9:0] pick_adc();
		int lo, hi, t;
		if ($urandom_range(0, 9) < 4)
			return 10'($urandom_range(0, 1023));
		lo = band_lo;
		hi = band_hi;
		if (lo > hi) begin t = lo; lo = hi; hi = t; end
		lo = (lo * 2 > 6) ? lo * 2 - 6 : 0;
		hi = hi * 2 + 8;
		return 10'($urandom_range(lo, hi));
	endfunction

	// write one register and mirror it into the model
	task automatic write_reg(ccam_pkg::cfg_idx_t idx, logic [6:0] val);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		case (idx)
			ccam_pkg::CFG_ALARM_EN:  al_en   = val[0];
			ccam_pkg::CFG_AL_HR_T:   al_ht   = val[1:0];
			ccam_pkg::CFG_AL_HR_O:   al_ho   = val[3:0];
			ccam_pkg::CFG_AL_MN_T:   al_mt   = val[2:0];
			ccam_pkg::CFG_AL_MN_O:   al_mo   = val[3:0];
			ccam_pkg::CFG_TEMP_LOW:  band_lo = val;
			ccam_pkg::CFG_TEMP_HIGH: band_hi = val;
			default: ;
		endcase
	endtask

	// offer one command, wait for the handshake, then log what it owes
	task automatic send_cmd(cmd_t c, logic chk = 1'b0, result_t typed_res = '0);
		int      gap;
		result_t owed;
		gap = src_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c.func;
		s_tdata  <= {2'b00, c.set_dy, c.set_mon, c.set_yr, c.set_mo, c.set_mt,
			c.set_ho, c.set_ht, c.adc};
		do @(posedge clk); while (!s_tready);
		owed = clock_after(c);
		expected_q.push_back(chk ? typed_res : owed);
		items_sent++;
	endtask

	// drop valid, let every owed result arrive, then wait out the extra cycles asked for
	task automatic settle_idle(int extra);
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Hang guard
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT) begin
			$display("clock_calendar_alarm_monitor test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Result side: random back-pressure, one long hold-off so the block
	// fills and stalls its input, and the check against the owed results.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int      stall;
		result_t got, want;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 15) == 0) snk_steady = !snk_steady;
			stall = snk_steady ? 0 : $urandom_range(0, 7);
			if (!long_hold_done && results_seen == HOLD_AT) begin
				long_hold_done = 1'b1;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);

			got.ht  = m_tdata[1:0];
			got.ho  = m_tdata[5:2];
			got.mt  = m_tdata[8:6];
			got.mo  = m_tdata[12:9];
			got.st  = m_tdata[15:13];
			got.so  = m_tdata[19:16];
			got.yr  = m_tdata[33:20];
			got.mon = m_tdata[37:34];
			got.dy  = m_tdata[42:38];
			got.deg = m_tdata[51:43];
			got.cls = m_tdata[53:52];
			got.bz  = m_tdata[54];

			if (expected_q.size() == 0) begin
				strays++;
				if (strays + mismatches <= MAX_REPORTS)
					$display("result %0d arrived with nothing owed", results_seen);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (strays + mismatches <= MAX_REPORTS) begin
						$display("result %0d mismatch", results_seen);
						$display("  exp %0d%0d:%0d%0d:%0d%0d y%0d m%0d d%0d deg %0d cls %0d bz %0d",
							want.ht, want.ho, want.mt, want.mo, want.st, want.so,
							want.yr, want.mon, want.dy, want.deg, want.cls, want.bz);
						$display("  got %0d%0d:%0d%0d:%0d%0d y%0d m%0d d%0d deg %0d cls %0d bz %0d",
							got.ht, got.ho, got.mt, got.mo, got.st, got.so,
							got.yr, got.mon, got.dy, got.deg, got.cls, got.bz);
					end
				end
			end
			results_seen++;
		end
	end

	// ------------------------------------------------------------------
	// Command side: directed table, then random runs per register setting
	// ------------------------------------------------------------------
	initial begin : command_source
		step_row_t  rows[$];
		logic [6:0] regv[7];
		int         phase_start, kind, n, stop_at, ht, ho, mt, mo;
		cmd_t       c;

		// model state and registers as they come out of reset
		now_ht = ccam_pkg::RST_HR_TENS;
		now_ho = ccam_pkg::RST_HR_ONES;
		now_mt = ccam_pkg::RST_MN_TENS;
		now_mo = ccam_pkg::RST_MN_ONES;
		now_st = 0; now_so = 0;
		now_yr  = ccam_pkg::RST_YEAR;
		now_mon = ccam_pkg::RST_MONTH;
		now_day = ccam_pkg::RST_DAY;
		bell_on = 0; bell_cnt = 0; therm_armed = 0; therm_deg = 0;
		al_en = 1'b0;
		al_ht = ccam_pkg::RST_AL_HR_T;
		al_ho = ccam_pkg::RST_AL_HR_O;
		al_mt = ccam_pkg::RST_AL_MN_T;
		al_mo = ccam_pkg::RST_AL_MN_O;
		band_lo = ccam_pkg::RST_T_LOW;
		band_hi = ccam_pkg::RST_T_HIGH;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table, run under the reset register values (band 18..25).
		// Stop with nothing ringing: reset state, nothing converted yet
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_STOP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(1, 2, 4, 5, 0, 0, 1400, 3, 20, 0, ccam_pkg::TS_BELOW, 1'b0)));
		// full-scale and zero samples while the beep is still disarmed
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_TICK, 1023, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(1, 2, 4, 5, 0, 1, 1400, 3, 20, 499, ccam_pkg::TS_ABOVE, 1'b0)));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(1, 2, 4, 5, 0, 2, 1400, 3, 20, 0, ccam_pkg::TS_BELOW, 1'b0)));
		// arm inside the band, leave above, stay out, re-arm on the band
		// edges, leave below, re-arm, leave just above
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_TICK, 45, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_TICK, 1023, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_TICK, 1023, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_TICK, 37, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_TICK, 53, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_TICK, 54, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0));
		// last day of the last year, hour loaded as 24: one tick wraps it all
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_LOAD_DATE, 0, 0, 0, 0, 0, 9999, 11, 29),
			1'b0, '0));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_LOAD_TIME, 0, 2, 4, 0, 0, 0, 0, 0),
			1'b0, '0));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_TICK, 40, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_res(0, 0, 0, 0, 0, 1, 0, 0, 0, 19, ccam_pkg::TS_WITHIN, 1'b0)));
		// all-ones loads, taken as given and rolled over on the next tick
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_LOAD_DATE, 0, 0, 0, 0, 0, 16383, 15, 31),
			1'b1, mk_res(0, 0, 0, 0, 0, 1, 16383, 15, 31, 19, ccam_pkg::TS_WITHIN, 1'b0)));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_LOAD_TIME, 0, 3, 15, 7, 15, 0, 0, 0), 1'b1,
			mk_res(3, 15, 7, 15, 0, 0, 16383, 15, 31, 19, ccam_pkg::TS_WITHIN, 1'b0)));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_TICK, 1023, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0));
		// all-zero loads
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_LOAD_TIME, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_LOAD_DATE, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_STOP, 1023, 3, 15, 7, 15, 16383, 15, 31),
			1'b0, '0));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_TICK, 512, 3, 15, 7, 15, 16383, 15, 31),
			1'b0, '0));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_LOAD_TIME, 0, 2, 3, 5, 9, 0, 0, 0),
			1'b0, '0));
		rows.push_back(step(mk_cmd(ccam_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0));

		foreach (rows[i])
			send_cmd(rows[i].cmd, rows[i].chk, rows[i].res);

		for (int p = 0; p < NUM_PHASES; p++) begin
			// registers only change with the block drained
			settle_idle(4);
			case (p)
				0: regv = '{7'd1, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd100};
				1: regv = '{7'd1, 7'd2, 7'd3, 7'd5, 7'd9, 7'd100, 7'd127};
				// alarm off, band inverted
				2: regv = '{7'd0, 7'($urandom_range(0, 2)), 7'($urandom_range(0, 3)),
					7'($urandom_range(0, 5)), 7'($urandom_range(0, 9)), 7'd30, 7'd10};
				3: regv = '{7'd1, 7'($urandom_range(0, 1)), 7'($urandom_range(0, 9)),
					7'($urandom_range(0, 5)), 7'($urandom_range(0, 9)),
					7'($urandom_range(0, 127)), 7'($urandom_range(0, 127))};
				// alarm digits over their full register widths
				default: regv = '{7'($urandom_range(0, 1)), 7'($urandom_range(0, 3)),
					7'($urandom_range(0, 15)), 7'($urandom_range(0, 7)),
					7'($urandom_range(0, 15)), 7'd0, 7'd127};
			endcase
			for (int r = 0; r < 7; r++)
				write_reg(ccam_pkg::cfg_idx_t'(r), regv[r]);

			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) == 0) src_steady = !src_steady;
				kind = $urandom_range(0, 9);
				if (kind < 4) begin
					// alarm run: load one minute before the alarm and tick, usually through
					// the match into the ring and now and then past its end
					ht = al_ht; ho = al_ho; mt = al_mt; mo = al_mo;
					if (mo > 0) begin
						mo--;
					end else begin
						mo = 9;
						if (mt > 0) begin
							mt--;
						end else begin
							mt = 5;
							if (ho > 0) begin
								ho--;
							end else if (ht > 0) begin
								ht--;
								ho = 9;
							end else begin
								ht = 2;
								ho = 3;
							end
						end
					end
					c = rand_cmd(ccam_pkg::FUNC_LOAD_TIME);
					c.set_ht = ht[1:0];
					c.set_ho = ho[3:0];
					c.set_mt = mt[2:0];
					c.set_mo = mo[3:0];
					send_cmd(c);
					n = $urandom_range(40, 130);
					stop_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n - 1) : -1;
					for (int k = 0; k < n; k++) begin
						if (k == stop_at)
							send_cmd(rand_cmd(ccam_pkg::FUNC_STOP));
						c = rand_cmd(ccam_pkg::FUNC_TICK);
						c.adc = pick_adc();
						send_cmd(c);
					end
				end else if (kind < 7) begin
					// rollover run: usually a late date and a late time, then ticks that often cross midnight
					c = rand_cmd(ccam_pkg::FUNC_LOAD_DATE);
					if ($urandom_range(0, 2) != 0) begin
						c.set_dy  = 5'($urandom_range(28, 29));
						c.set_mon = 4'($urandom_range(10, 11));
						c.set_yr  = ($urandom_range(0, 1) == 0) ? 14'd9999
							: 14'($urandom_range(0, 9999));
					end
					send_cmd(c);
					c = rand_cmd(ccam_pkg::FUNC_LOAD_TIME);
					if ($urandom_range(0, 3) != 0) begin
						c.set_ht = 2'd2;
						c.set_ho = 4'd3;
						c.set_mt = 3'd5;
						c.set_mo = 4'd9;
					end
					send_cmd(c);
					n = $urandom_range(55, 70);
					for (int k = 0; k < n; k++) begin
						c = rand_cmd(ccam_pkg::FUNC_TICK);
						c.adc = pick_adc();
						send_cmd(c);
					end
				end else begin
					// noise: any command, any field contents
					n = $urandom_range(1, 8);
					for (int k = 0; k < n; k++)
						send_cmd(rand_cmd(ccam_pkg::func_t'($urandom_range(0, 3))));
				end
			end
		end

		settle_idle(10);
		if (mismatches == 0 && strays == 0 && expected_q.size() == 0)
			$display("clock_calendar_alarm_monitor test passed");
		else
			$display("clock_calendar_alarm_monitor test failed");
		$finish;
	end

endmodule

### filelist.f
src/ccam_pkg.sv
src/clock_calendar_alarm_monitor.sv
tb/clock_calendar_alarm_monitor_tb.sv
